// ===== hdl/amtp_pkg.sv =====
package amtp_pkg;

   localparam int DataWidth = 48;
   localparam int Steps = 1024;
   localparam int SlotWidth = 10;
   localparam int CountWidth = 11;
   localparam int CsrDataWidth = 48;
   localparam int CsrIndexWidth = 1;

   localparam logic [1:0] CmdSet = 2'd0;
   localparam logic [1:0] CmdAdd = 2'd1;

   localparam logic [CsrIndexWidth-1:0] CsrIndexMode = 1'd0;
   localparam logic [CsrIndexWidth-1:0] CsrStartTime = 1'd1;

   typedef logic [DataWidth-1:0] data_type;

   typedef struct packed {
      logic [1:0]           command;
      data_type             new_value;
      logic signed [DataWidth-1:0] delta;
      data_type             time_now;
      data_type             location;
      logic [SlotWidth-1:0] read_slot;
   } req_type;

   typedef struct packed {
      data_type              slot_min;
      data_type              slot_max;
      data_type              slot_index_offset;
      data_type              slot_time_offset;
      data_type              slot_location;
      logic                  slot_valid;
      logic [CountWidth-1:0] stored_count;
      data_type              peak_level;
      data_type              peak_index_offset;
      data_type              peak_time_offset;
      logic                  location_seen;
   } rsp_type;

   typedef struct packed {
      data_type mn;
      data_type mx;
      data_type idx;
      data_type tm;
      data_type loc;
   } bin_type;

endpackage

// ===== hdl/adaptive_minmax_timeline_profiler_core.sv =====
// Adaptive min/max timeline profiler core.
// A request beat on req_* carries a command (set level, add a signed delta,
// or read) and a slot number; every accepted beat yields exactly one beat on
// rsp_* holding the stored entry for that slot plus the peak and count totals.
// The interval table lives in one simple dual-port synchronous memory with a
// registered read. A request is taken only in the idle state. An ordinary beat
// goes from the update state to the output state, where it loads the response
// register; a beat that appends a closed interval to the table passes a read
// state in between, because the slot read must follow the write. The next
// request is taken the cycle after the response register loads, so beats are
// handled one at a time.
// When an interval closes while the table is full, the table is compacted:
// one entry is read and folded per cycle, and req_stall stays high meanwhile.
// While rsp_stall is high the response beat holds; a following request may be
// taken and processed, but its response waits until the register is free.
// Reset (synchronous, active high) and every csr_ write return the profile to
// its empty state under the register values; the table memory is not cleared.
// The user must write registers only while nothing is in flight; not enforced.
module adaptive_minmax_timeline_profiler_core
   import amtp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_type                  rsp_data,
   input  logic                     csr_write,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata
);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b00000001,
      ST_UPD   = 8'b00000010,
      ST_CSEED = 8'b00000100,
      ST_CWALK = 8'b00001000,
      ST_CEND  = 8'b00010000,
      ST_CAPP  = 8'b00100000,
      ST_RD    = 8'b01000000,
      ST_OUT   = 8'b10000000
   } state_type;

   state_type state_ff, state_in;
   req_type req_ff, req_in;
   logic mode_ff, mode_in;
   data_type start_ff, start_in;
   data_type level_ff, level_in, ucount_ff, ucount_in;
   logic [CountWidth-1:0] count_ff, count_in;
   bin_type open_ff, open_in, acc_ff, acc_in;
   logic open_valid_ff, open_valid_in;
   data_type iend_ff, iend_in, iwidth_ff, iwidth_in;
   data_type peak_ff, peak_in, pidx_ff, pidx_in, ptime_ff, ptime_in;
   logic saw_ff, saw_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   data_type idx_ff, idx_in;
   logic [DataWidth+1:0] bound_ff, bound_in;
   logic [SlotWidth-1:0] rptr_ff, rptr_in, wptr_ff, wptr_in;

   bin_type mem [Steps];
   bin_type rdata_ff;
   logic mem_we;
   logic [SlotWidth-1:0] wr_addr, rd_addr;
   bin_type mem_wdata;

   logic is_update, rsp_busy, init_req;
   data_type si, si_new, idx_now, new_level, diff, w_calc;
   logic [DataWidth:0] diff_x2;
   bin_type upd_open, fresh_open, compact_open, fold_res;

   function automatic bin_type fold_f(bin_type acc, bin_type e);
      bin_type r;
      r = acc;
      if (e.idx > acc.idx) r.idx = e.idx;
      if (e.tm > acc.tm) begin
         r.tm = e.tm;
         r.loc = e.loc;
      end
      if (e.mx > acc.mx) r.mx = e.mx;
      if (e.mn < acc.mn) r.mn = e.mn;
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (mem_we) mem[wr_addr] <= mem_wdata;
      rdata_ff <= mem[rd_addr];
   end

   assign si = mode_ff ? '0 : start_ff;
   assign is_update = (req_ff.command == CmdSet) || (req_ff.command == CmdAdd);
   assign rsp_busy = rsp_valid_ff && rsp_stall;
   assign init_req = reset || csr_write;
   assign req_stall = reset || (state_ff != ST_IDLE);

   always_comb begin
      unique case (req_ff.command)
         CmdSet:  new_level = req_ff.new_value;
         CmdAdd:  new_level = level_ff + data_type'(req_ff.delta);
         default: new_level = level_ff;
      endcase
      idx_now = mode_ff ? ucount_ff : req_ff.time_now;
      diff = idx_now - si;
      diff_x2 = {diff, 1'b0};
      // Steps is a power of two, so twice the span over Steps is a plain shift.
      w_calc = data_type'(diff_x2 >> $clog2(Steps));
      if (w_calc == '0) w_calc = data_type'(1);
      upd_open.mn = (new_level < open_ff.mn) ? new_level : open_ff.mn;
      upd_open.mx = (new_level > open_ff.mx) ? new_level : open_ff.mx;
      upd_open.idx = idx_now;
      upd_open.tm = req_ff.time_now;
      upd_open.loc = req_ff.location;
      fresh_open = '{mn: new_level, mx: new_level, idx: idx_now,
                     tm: req_ff.time_now, loc: req_ff.location};
      compact_open = '{mn: level_ff, mx: level_ff, idx: idx_ff,
                       tm: req_ff.time_now, loc: req_ff.location};
      fold_res = fold_f(acc_ff, rdata_ff);
   end

   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      mode_in = mode_ff;
      start_in = start_ff;
      level_in = level_ff;
      ucount_in = ucount_ff;
      count_in = count_ff;
      open_in = open_ff;
      open_valid_in = open_valid_ff;
      iend_in = iend_ff;
      iwidth_in = iwidth_ff;
      peak_in = peak_ff;
      pidx_in = pidx_ff;
      ptime_in = ptime_ff;
      saw_in = saw_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      acc_in = acc_ff;
      idx_in = idx_ff;
      bound_in = bound_ff;
      rptr_in = rptr_ff;
      wptr_in = wptr_ff;
      mem_we = 1'b0;
      wr_addr = count_ff[SlotWidth-1:0];
      rd_addr = req_ff.read_slot;
      mem_wdata = open_ff;

      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            // Without a write the slot read issued here is already valid.
            state_in = ST_OUT;
            if (is_update) begin
               level_in = new_level;
               ucount_in = ucount_ff + data_type'(1);
               if (req_ff.location != '0) saw_in = 1'b1;
               if (new_level > peak_ff) begin
                  peak_in = new_level;
                  pidx_in = idx_now;
                  ptime_in = req_ff.time_now;
               end
               open_valid_in = 1'b1;
               if (open_valid_ff && idx_now > iend_ff) begin
                  if (count_ff >= CountWidth'(Steps)) begin
                     // The old open interval stays put until the walk is done.
                     iwidth_in = w_calc;
                     idx_in = idx_now;
                     bound_in = {2'b00, si} + {2'b00, w_calc};
                     wptr_in = '0;
                     rd_addr = '0;
                     state_in = ST_CSEED;
                  end else begin
                     mem_we = 1'b1;
                     count_in = count_ff + CountWidth'(1);
                     iend_in = iend_ff + iwidth_ff;
                     open_in = fresh_open;
                     state_in = ST_RD;
                  end
               end else begin
                  open_in = upd_open;
               end
            end
         end
         ST_CSEED: begin
            acc_in = rdata_ff;
            rptr_in = SlotWidth'(1);
            rd_addr = SlotWidth'(1);
            state_in = ST_CWALK;
         end
         ST_CWALK: begin
            // Writes always land below the entry being read, so no hazard.
            rd_addr = rptr_ff + SlotWidth'(1);
            if ({2'b00, rdata_ff.idx} > bound_ff) begin
               mem_we = 1'b1;
               wr_addr = wptr_ff;
               mem_wdata = acc_ff;
               acc_in = rdata_ff;
               wptr_in = wptr_ff + SlotWidth'(1);
               bound_in = bound_ff + {2'b00, iwidth_ff};
            end else begin
               acc_in = fold_res;
            end
            rptr_in = rptr_ff + SlotWidth'(1);
            if (rptr_ff == SlotWidth'(Steps - 1)) state_in = ST_CEND;
         end
         ST_CEND: begin
            // The last merged bin is always kept.
            mem_we = 1'b1;
            wr_addr = wptr_ff;
            if (wptr_ff == SlotWidth'(Steps - 1)) begin
               // Nothing merged: the closing interval folds into the last entry.
               mem_wdata = fold_f(acc_ff, open_ff);
               count_in = CountWidth'(Steps);
               open_in = compact_open;
               iend_in = idx_ff + iwidth_ff + iwidth_ff;
               state_in = ST_RD;
            end else begin
               mem_wdata = acc_ff;
               state_in = ST_CAPP;
            end
         end
         ST_CAPP: begin
            mem_we = 1'b1;
            wr_addr = wptr_ff + SlotWidth'(1);
            mem_wdata = open_ff;
            count_in = {1'b0, wptr_ff} + CountWidth'(2);
            open_in = compact_open;
            iend_in = idx_ff + iwidth_ff + iwidth_ff;
            state_in = ST_RD;
         end
         ST_RD: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_busy) begin
               rsp_in = '0;
               if (CountWidth'(req_ff.read_slot) < count_ff) begin
                  rsp_in.slot_min = rdata_ff.mn;
                  rsp_in.slot_max = rdata_ff.mx;
                  rsp_in.slot_index_offset = rdata_ff.idx - si;
                  rsp_in.slot_time_offset = rdata_ff.tm - start_ff;
                  rsp_in.slot_location = rdata_ff.loc;
                  rsp_in.slot_valid = 1'b1;
               end
               rsp_in.stored_count = count_ff;
               rsp_in.peak_level = peak_ff;
               rsp_in.peak_index_offset = pidx_ff - si;
               rsp_in.peak_time_offset = ptime_ff - start_ff;
               rsp_in.location_seen = saw_ff;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (csr_write) begin
         if (csr_index == CsrIndexMode) mode_in = csr_wdata[0];
         else if (csr_index == CsrStartTime) start_in = csr_wdata;
      end
   end

   always_comb begin
      si_new = (reset || mode_in) ? '0 : start_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         mode_ff <= 1'b0;
         start_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         mode_ff <= mode_in;
         start_ff <= start_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      acc_ff <= acc_in;
      idx_ff <= idx_in;
      bound_ff <= bound_in;
      rptr_ff <= rptr_in;
      wptr_ff <= wptr_in;
      if (init_req) begin
         level_ff <= '0;
         ucount_ff <= '0;
         count_ff <= '0;
         open_ff <= '{mn: '1, mx: '0, idx: '0, tm: '0, loc: '0};
         open_valid_ff <= 1'b0;
         iwidth_ff <= data_type'(1);
         iend_ff <= si_new + data_type'(1);
         peak_ff <= '0;
         pidx_ff <= si_new;
         ptime_ff <= reset ? '0 : start_in;
         saw_ff <= 1'b0;
      end else begin
         level_ff <= level_in;
         ucount_ff <= ucount_in;
         count_ff <= count_in;
         open_ff <= open_in;
         open_valid_ff <= open_valid_in;
         iwidth_ff <= iwidth_in;
         iend_ff <= iend_in;
         peak_ff <= peak_in;
         pidx_ff <= pidx_in;
         ptime_ff <= ptime_in;
         saw_ff <= saw_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

`ifndef NO_ASSERTIONS
   a_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");
   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(Steps)) else $error("bin count overflow");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response beat changed");
`endif

endmodule

// ===== test/adaptive_minmax_timeline_profiler_core_test.sv =====
`timescale 1ns / 1ps

module adaptive_minmax_timeline_profiler_core_test;
   import amtp_pkg::*;

   localparam logic [1:0] CmdRead = 2'd2;
   localparam logic [1:0] CmdIdle = 2'd3;
   localparam data_type AllOnes = {DataWidth{1'b1}};
   localparam int StallLimit = 20000;

   typedef struct {
      req_type r;
      bit      fixed;
      rsp_type e;
   } row_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall;
   req_type req_data;
   rsp_type rsp_data;
   logic csr_write;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0] csr_wdata;

   adaptive_minmax_timeline_profiler_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Profile mirror.
   logic     by_count;
   data_type origin;
   data_type lvl, upd_cnt;
   bin_type  tbl [Steps];
   int       tbl_cnt;
   bin_type  open_bin;
   bit       open_ok;
   data_type iv_end, iv_width, pk_lvl, pk_idx, pk_tm;
   bit       loc_seen;

   rsp_type  pending_rsp [$];
   int       errors = 0;
   bit       quiet = 1'b0;
   data_type clk_ticks;

   function automatic data_type first_index();
      return by_count ? '0 : origin;
   endfunction

   function automatic void clear_open();
      open_bin = '{mn: AllOnes, mx: '0, idx: '0, tm: '0, loc: '0};
      open_ok = 1'b0;
   endfunction

   function automatic void restart_profile();
      lvl = '0;
      upd_cnt = '0;
      tbl_cnt = 0;
      clear_open();
      iv_width = 1;
      iv_end = first_index() + 1;
      pk_lvl = '0;
      pk_idx = first_index();
      pk_tm = origin;
      loc_seen = 1'b0;
   endfunction

   function automatic void merge_into(ref bin_type acc, input bin_type e);
      if (e.idx > acc.idx) acc.idx = e.idx;
      if (e.tm > acc.tm) begin
         acc.tm = e.tm;
         acc.loc = e.loc;
      end
      if (e.mx > acc.mx) acc.mx = e.mx;
      if (e.mn < acc.mn) acc.mn = e.mn;
   endfunction

   function automatic void coarsen(data_type idx);
      data_type si;
      longint unsigned span, w, bound, nout;
      bin_type acc;
      si = first_index();
      span = 64'(data_type'(idx - si));
      w = (span * 2) / Steps;
      if (w == 0) w = 1;
      iv_width = data_type'(w);
      nout = 0;
      acc = tbl[0];
      for (int i = 1; i < Steps; i++) begin
         bound = 64'(si) + (nout + 1) * w;
         if (64'(tbl[i].idx) > bound) begin
            tbl[nout] = acc;
            nout++;
            acc = tbl[i];
         end else begin
            merge_into(acc, tbl[i]);
         end
      end
      tbl[nout] = acc;
      tbl_cnt = int'(nout) + 1;
      iv_end = idx + data_type'(w);
   endfunction

   function automatic void close_interval(data_type idx);
      if (!open_ok) return;
      if (tbl_cnt >= Steps) coarsen(idx);
      if (tbl_cnt >= Steps) begin
         merge_into(tbl[Steps-1], open_bin);
         tbl_cnt = Steps;
      end else begin
         tbl[tbl_cnt] = open_bin;
         tbl_cnt++;
      end
      clear_open();
      iv_end = iv_end + iv_width;
   endfunction

   function automatic rsp_type profile_step(req_type r);
      rsp_type o;
      data_type idx;
      o = '0;
      if (r.command == CmdSet || r.command == CmdAdd) begin
         if (r.command == CmdSet) lvl = r.new_value;
         else lvl = lvl + data_type'(r.delta);
         idx = by_count ? upd_cnt : r.time_now;
         if (r.location != 0) loc_seen = 1'b1;
         if (idx > iv_end) close_interval(idx);
         if (lvl > open_bin.mx) open_bin.mx = lvl;
         if (lvl < open_bin.mn) open_bin.mn = lvl;
         open_bin.idx = idx;
         open_bin.tm = r.time_now;
         open_bin.loc = r.location;
         open_ok = 1'b1;
         if (lvl > pk_lvl) begin
            pk_lvl = lvl;
            pk_idx = idx;
            pk_tm = r.time_now;
         end
         upd_cnt = upd_cnt + 1;
      end
      if (int'(r.read_slot) < tbl_cnt) begin
         o.slot_min = tbl[r.read_slot].mn;
         o.slot_max = tbl[r.read_slot].mx;
         o.slot_index_offset = tbl[r.read_slot].idx - first_index();
         o.slot_time_offset = tbl[r.read_slot].tm - origin;
         o.slot_location = tbl[r.read_slot].loc;
         o.slot_valid = 1'b1;
      end
      o.stored_count = CountWidth'(tbl_cnt);
      o.peak_level = pk_lvl;
      o.peak_index_offset = pk_idx - first_index();
      o.peak_time_offset = pk_tm - origin;
      o.location_seen = loc_seen;
      return o;
   endfunction

   function automatic data_type rand48();
      return data_type'({$urandom, $urandom});
   endfunction

   function automatic req_type make_req(logic [1:0] cmd, data_type nv, data_type dl,
                                        data_type t, data_type loc, int slot);
      req_type r;
      r.command = cmd;
      r.new_value = nv;
      r.delta = dl;
      r.time_now = t;
      r.location = loc;
      r.read_slot = SlotWidth'(slot);
      return r;
   endfunction

   // Drives one beat and holds it until taken; unless quiet is set, it may then drop req_valid for a random gap.
   task automatic send_beat(req_type r, bit fixed, rsp_type e);
      rsp_type p;
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      p = profile_step(r);
      pending_rsp.push_back(fixed ? e : p);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [CsrIndexWidth-1:0] idx, data_type val);
      drain();
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CsrIndexMode) by_count = val[0];
      else origin = val;
      restart_profile();
      clk_ticks = origin;
   endtask

   task automatic random_beats(int n, int update_pct);
      req_type r;
      int pick;
      for (int k = 0; k < n; k++) begin
         r.command = ($urandom_range(1, 100) <= update_pct) ? 2'($urandom_range(0, 1))
                   : ($urandom_range(0, 4) == 0 ? CmdIdle : CmdRead);
         pick = $urandom_range(0, 9);
         r.new_value = pick < 4 ? rand48() : data_type'($urandom_range(0, 1000));
         r.delta = pick > 6 ? rand48() : data_type'(int'($urandom_range(0, 40)) - 20);
         pick = $urandom_range(0, 19);
         if (pick == 0) clk_ticks = rand48();
         else if (pick == 1) clk_ticks = clk_ticks - $urandom_range(1, 8);
         else clk_ticks = clk_ticks + $urandom_range(0, 3);
         r.time_now = clk_ticks;
         pick = $urandom_range(0, 3);
         r.location = pick == 0 ? '0 : (pick == 1 ? rand48() : data_type'($urandom_range(1, 64)));
         r.read_slot = ($urandom_range(0, 3) == 0 || tbl_cnt == 0) ? SlotWidth'($urandom)
                     : SlotWidth'($urandom_range(0, tbl_cnt - 1));
         send_beat(r, 1'b0, '0);
      end
   endtask

   task automatic check_field(string name, logic [63:0] e, logic [63:0] a);
      if (e !== a) begin
         errors++;
         $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, e, a);
      end
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            errors++;
            $display("%0t: unexpected beat, expected none, actual %h", $realtime, rsp_data);
         end else begin
            e = pending_rsp.pop_front();
            check_field("slot_min", e.slot_min, rsp_data.slot_min);
            check_field("slot_max", e.slot_max, rsp_data.slot_max);
            check_field("slot_index_offset", e.slot_index_offset, rsp_data.slot_index_offset);
            check_field("slot_time_offset", e.slot_time_offset, rsp_data.slot_time_offset);
            check_field("slot_location", e.slot_location, rsp_data.slot_location);
            check_field("slot_valid", e.slot_valid, rsp_data.slot_valid);
            check_field("stored_count", e.stored_count, rsp_data.stored_count);
            check_field("peak_level", e.peak_level, rsp_data.peak_level);
            check_field("peak_index_offset", e.peak_index_offset, rsp_data.peak_index_offset);
            check_field("peak_time_offset", e.peak_time_offset, rsp_data.peak_time_offset);
            check_field("location_seen", e.location_seen, rsp_data.location_seen);
         end
      end
   end

   int stall_left = 0;
   always @(posedge clock) begin
      int s;
      s = stall_left;
      if (s == 0 && !quiet && $urandom_range(0, 5) == 0) s = $urandom_range(1, 5);
      if (s > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= s - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   int silent_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset || csr_write)
         silent_cycles <= 0;
      else if (silent_cycles >= StallLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end else
         silent_cycles <= silent_cycles + 1;
   end

   initial begin
      row_type rows [$];
      rsp_type top;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_write <= 1'b0;
      csr_index <= CsrIndexMode;
      csr_wdata <= '0;
      by_count = 1'b0;
      origin = '0;
      restart_profile();
      clk_ticks = '0;
      top = '0;
      top.peak_level = AllOnes;

      rows.push_back('{make_req(CmdRead, '0, '0, '0, '0, 0), 1'b1, rsp_type'('0)});
      rows.push_back('{make_req(CmdIdle, AllOnes, AllOnes, AllOnes, AllOnes, 1023), 1'b1,
                       rsp_type'('0)});
      rows.push_back('{make_req(CmdSet, AllOnes, '0, '0, '0, 1023), 1'b1, top});
      rows.push_back('{make_req(CmdAdd, '0, 48'd1, 48'd1, AllOnes, 0), 1'b0, '0});
      rows.push_back('{make_req(CmdAdd, '0, 48'h8000_0000_0000, 48'd2, 48'd1, 0), 1'b0, '0});
      rows.push_back('{make_req(CmdAdd, '0, 48'h7fff_ffff_ffff, 48'd5, '0, 1), 1'b0, '0});
      rows.push_back('{make_req(CmdSet, '0, '0, AllOnes, AllOnes, 0), 1'b0, '0});
      rows.push_back('{make_req(CmdSet, 48'd12345, '0, 48'd3, 48'd7, 1), 1'b0, '0});
      rows.push_back('{make_req(CmdRead, '0, '0, '0, '0, 2), 1'b0, '0});
      rows.push_back('{make_req(CmdAdd, '0, AllOnes, AllOnes, '0, 2), 1'b0, '0});
      rows.push_back('{make_req(CmdRead, '0, '0, '0, '0, 3), 1'b0, '0});
      rows.push_back('{make_req(CmdSet, 48'h5555_5555_5555, '0, AllOnes,
                                48'haaaa_aaaa_aaaa, 0), 1'b0, '0});
      rows.push_back('{make_req(CmdIdle, '0, '0, '0, '0, 1), 1'b0, '0});

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) send_beat(rows[i].r, rows[i].fixed, rows[i].e);

      // Count mode closes an interval on nearly every update, so the table fills quickly.
      write_reg(CsrIndexMode, 48'd1);
      write_reg(CsrStartTime, AllOnes);
      random_beats(400, 90);

      write_reg(CsrIndexMode, 48'd0);
      write_reg(CsrStartTime, '0);
      random_beats(100, 75);
      drain();
      random_beats(100, 75);

      write_reg(CsrStartTime, rand48());
      random_beats(150, 75);

      write_reg(CsrStartTime, AllOnes);
      quiet = 1'b1;
      random_beats(90, 75);

      drain();
      repeat (2100) @(posedge clock);
      if (errors == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/amtp_pkg.sv
hdl/adaptive_minmax_timeline_profiler_core.sv
test/adaptive_minmax_timeline_profiler_core_test.sv
